// ===== sv/dmsr_pkg.sv =====
// ----------------------------------------------------------------------------
// dmsr_pkg
// shared types, codes and the motion command table for the speed ramp block
// ----------------------------------------------------------------------------
package dmsr_pkg;

    // width of the internal rate registers and targets
    localparam int RATE_BITS = 16;
    // fixed widths of the configuration values and the result rate fields
    localparam int CFG_RATE_BITS = 16;
    localparam int OUT_RATE_BITS = 16;
    localparam int SUM_BITS = ((RATE_BITS > CFG_RATE_BITS) ? RATE_BITS : CFG_RATE_BITS) + 1;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 3;

    typedef logic [RATE_BITS-1:0]     rate_t;
    typedef logic [CFG_RATE_BITS-1:0] cfg_rate_t;
    typedef logic [OUT_RATE_BITS-1:0] out_rate_t;
    typedef logic [SUM_BITS-1:0]      sum_t;

    localparam rate_t RATE_MAX = '1;

    // configuration register indexes
    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_FAST_RATE        = 3'd0,
        REG_SLOW_RATE        = 3'd1,
        REG_RAMP_INCREMENT   = 3'd2,
        REG_INVERT_LEFT_DIR  = 3'd3,
        REG_INVERT_RIGHT_DIR = 3'd4
    } reg_idx_t;

    localparam cfg_rate_t FAST_RATE_RESET = 16'd350;
    localparam cfg_rate_t SLOW_RATE_RESET = 16'd180;
    localparam cfg_rate_t RAMP_INC_RESET  = 16'd25;

    // item action codes
    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_COMMAND = 2'd1,
        ACT_ENABLE  = 2'd2
    } action_t;

    // motion command codes
    typedef enum logic [3:0] {
        CMD_HALT       = 4'd0,
        CMD_FWD        = 4'd1,
        CMD_BACK       = 4'd2,
        CMD_SPIN_LEFT  = 4'd3,
        CMD_SPIN_RIGHT = 4'd4,
        CMD_FWD_LEFT   = 4'd5,
        CMD_FWD_RIGHT  = 4'd6,
        CMD_BACK_LEFT  = 4'd7,
        CMD_BACK_RIGHT = 4'd8
    } command_t;

    // decoded motion: direction and fast/slow choice per side
    typedef struct packed {
        logic moving;
        logic fwd_left;
        logic fwd_right;
        logic slow_left;
        logic slow_right;
    } motion_t;

    function automatic motion_t cmd_decode(logic [3:0] cmd);
        motion_t m;
        m = '0;
        case (command_t'(cmd))
            CMD_FWD:        m = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
            CMD_BACK:       m = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
            CMD_SPIN_LEFT:  m = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
            CMD_SPIN_RIGHT: m = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
            CMD_FWD_LEFT:   m = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
            CMD_FWD_RIGHT:  m = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
            CMD_BACK_LEFT:  m = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
            CMD_BACK_RIGHT: m = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
            default:        m = '0;
        endcase
        return m;
    endfunction

    // clamp a configured rate into the rate register range
    function automatic rate_t sat_rate(cfg_rate_t v);
        rate_t r;
        if (sum_t'(v) > sum_t'(RATE_MAX)) begin
            r = RATE_MAX;
        end else begin
            r = rate_t'(v);
        end
        return r;
    endfunction

endpackage

// ===== sv/dual_motor_speed_ramp.sv =====
// ----------------------------------------------------------------------------
// dual_motor_speed_ramp
// pulse rate ramp generator for a two-motor differential stepper drive
// ----------------------------------------------------------------------------
// Each accepted item is a ramp tick, a motion command or an enable change, and
// each gives exactly one result item: both current pulse rates, both latched
// direction pin levels and the active-low driver enable level. The state
// update of an item is a single pass of the command table decode
// and one add/compare per side, written into the state registers and the
// result register at the accept edge. A new item is taken every cycle while
// the result register is empty or being drained, so the block sustains one
// item per cycle. Commands set per-side targets (fast or slow rate, clamped
// to the rate range); ticks latch the direction pins through the per-motor
// inversion bits and move each rate toward its target by ramp_increment.
// While disabled, ticks clear rates and targets and commands clear targets.
// Registers sit on an APB-style port at byte addresses 0,4,8,12,16 and
// should only be written while no item is in flight.
// ----------------------------------------------------------------------------
module dual_motor_speed_ramp (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dmsr_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [dmsr_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [dmsr_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    // item input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_action,
    input  logic [3:0]                          s_command,
    input  logic                                s_enable_value,
    // result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output dmsr_pkg::out_rate_t                 m_rate_left,
    output dmsr_pkg::out_rate_t                 m_rate_right,
    output logic                                m_dir_pin_left,
    output logic                                m_dir_pin_right,
    output logic                                m_enable_pin_level
);
    import dmsr_pkg::*;

    // configuration registers
    cfg_rate_t fast_rate_reg;
    cfg_rate_t slow_rate_reg;
    cfg_rate_t ramp_inc_reg;
    logic      inv_left_reg;
    logic      inv_right_reg;

    // block state
    logic  running_reg,     running_next;
    rate_t cur_left_reg,    cur_left_next;
    rate_t cur_right_reg,   cur_right_next;
    rate_t tgt_left_reg,    tgt_left_next;
    rate_t tgt_right_reg,   tgt_right_next;
    logic  fwd_left_reg,    fwd_left_next;
    logic  fwd_right_reg,   fwd_right_next;
    logic  pin_left_reg,    pin_left_next;
    logic  pin_right_reg,   pin_right_next;

    // result register
    logic      m_valid_reg;
    out_rate_t m_rate_left_reg;
    out_rate_t m_rate_right_reg;
    logic      m_dir_left_reg;
    logic      m_dir_right_reg;
    logic      m_en_pin_reg;

    logic             s_accept;
    logic             cfg_write;
    reg_idx_t         cfg_idx;
    motion_t          motion;
    rate_t            fast_sat;
    rate_t            slow_sat;
    rate_t            ramp_left;
    rate_t            ramp_right;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_rate_reg <= FAST_RATE_RESET;
            slow_rate_reg <= SLOW_RATE_RESET;
            ramp_inc_reg  <= RAMP_INC_RESET;
            inv_left_reg  <= 1'b1;
            inv_right_reg <= 1'b0;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_FAST_RATE:        fast_rate_reg <= pwdata[CFG_RATE_BITS-1:0];
                REG_SLOW_RATE:        slow_rate_reg <= pwdata[CFG_RATE_BITS-1:0];
                REG_RAMP_INCREMENT:   ramp_inc_reg  <= pwdata[CFG_RATE_BITS-1:0];
                REG_INVERT_LEFT_DIR:  inv_left_reg  <= pwdata[0];
                REG_INVERT_RIGHT_DIR: inv_right_reg <= pwdata[0];
                default: ;  // unmapped addresses ignore writes
            endcase
        end
    end

    // read data, zero-extended
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_FAST_RATE:        prdata = APB_DATA_BITS'(fast_rate_reg);
            REG_SLOW_RATE:        prdata = APB_DATA_BITS'(slow_rate_reg);
            REG_RAMP_INCREMENT:   prdata = APB_DATA_BITS'(ramp_inc_reg);
            REG_INVERT_LEFT_DIR:  prdata = APB_DATA_BITS'(inv_left_reg);
            REG_INVERT_RIGHT_DIR: prdata = APB_DATA_BITS'(inv_right_reg);
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake: the result register drains while the next item enters
    // ------------------------------------------------------------------
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // ------------------------------------------------------------------
    // single-pass state update
    // ------------------------------------------------------------------
    assign motion   = cmd_decode(s_command);
    assign fast_sat = sat_rate(fast_rate_reg);
    assign slow_sat = sat_rate(slow_rate_reg);

    // ramp steps use the targets as they stand before the item
    dmsr_ramp_step u_ramp_left (
        .cur  (cur_left_reg),
        .tgt  (tgt_left_reg),
        .step (ramp_inc_reg),
        .nxt  (ramp_left)
    );

    dmsr_ramp_step u_ramp_right (
        .cur  (cur_right_reg),
        .tgt  (tgt_right_reg),
        .step (ramp_inc_reg),
        .nxt  (ramp_right)
    );

    always_comb begin
        running_next   = running_reg;
        cur_left_next  = cur_left_reg;
        cur_right_next = cur_right_reg;
        tgt_left_next  = tgt_left_reg;
        tgt_right_next = tgt_right_reg;
        fwd_left_next  = fwd_left_reg;
        fwd_right_next = fwd_right_reg;
        pin_left_next  = pin_left_reg;
        pin_right_next = pin_right_reg;

        case (action_t'(s_action))
            ACT_TICK: begin
                if (!running_reg) begin
                    // tick while disabled clears rates and targets
                    cur_left_next  = '0;
                    cur_right_next = '0;
                    tgt_left_next  = '0;
                    tgt_right_next = '0;
                end else begin
                    pin_left_next  = fwd_left_reg ^ inv_left_reg;
                    pin_right_next = fwd_right_reg ^ inv_right_reg;
                    cur_left_next  = ramp_left;
                    cur_right_next = ramp_right;
                end
            end
            ACT_COMMAND: begin
                if (running_reg && motion.moving) begin
                    fwd_left_next  = motion.fwd_left;
                    fwd_right_next = motion.fwd_right;
                    tgt_left_next  = motion.slow_left ? slow_sat : fast_sat;
                    tgt_right_next = motion.slow_right ? slow_sat : fast_sat;
                end else begin
                    // stop, unknown command or disabled: targets to zero
                    tgt_left_next  = '0;
                    tgt_right_next = '0;
                end
            end
            ACT_ENABLE: begin
                if (!s_enable_value) begin
                    cur_left_next  = '0;
                    cur_right_next = '0;
                    tgt_left_next  = '0;
                    tgt_right_next = '0;
                end
                running_next = s_enable_value;
            end
            default: ;  // unused action code leaves the state alone
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg   <= 1'b0;
            cur_left_reg  <= '0;
            cur_right_reg <= '0;
            tgt_left_reg  <= '0;
            tgt_right_reg <= '0;
            fwd_left_reg  <= 1'b1;
            fwd_right_reg <= 1'b1;
            pin_left_reg  <= 1'b0;
            pin_right_reg <= 1'b1;
        end else if (s_accept) begin
            running_reg   <= running_next;
            cur_left_reg  <= cur_left_next;
            cur_right_reg <= cur_right_next;
            tgt_left_reg  <= tgt_left_next;
            tgt_right_reg <= tgt_right_next;
            fwd_left_reg  <= fwd_left_next;
            fwd_right_reg <= fwd_right_next;
            pin_left_reg  <= pin_left_next;
            pin_right_reg <= pin_right_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_rate_left_reg  <= out_rate_t'(cur_left_next);
            m_rate_right_reg <= out_rate_t'(cur_right_next);
            m_dir_left_reg   <= pin_left_next;
            m_dir_right_reg  <= pin_right_next;
            m_en_pin_reg     <= !running_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_rate_left        = m_rate_left_reg;
    assign m_rate_right       = m_rate_right_reg;
    assign m_dir_pin_left     = m_dir_left_reg;
    assign m_dir_pin_right    = m_dir_right_reg;
    assign m_enable_pin_level = m_en_pin_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a disabled block holds no rate and no target
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> (cur_left_reg == '0) && (cur_right_reg == '0) &&
                         (tgt_left_reg == '0) && (tgt_right_reg == '0))
        else $error("rates or targets nonzero while disabled");

    // every accepted item leaves a result behind
    a_item_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid_reg)
        else $error("accepted item produced no result");

    // the shown enable level matches the state that produced it
    a_enable_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_en_pin_reg == !running_reg))
        else $error("enable pin disagrees with running state");

    // an empty result register never stalls the input
    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with empty result register");

endmodule

// ===== sv/dmsr_ramp_step.sv =====
// ----------------------------------------------------------------------------
// dmsr_ramp_step
// one ramp step of a single side: move toward target, clamped at target and 0
// ----------------------------------------------------------------------------
module dmsr_ramp_step (
    input  dmsr_pkg::rate_t     cur,
    input  dmsr_pkg::rate_t     tgt,
    input  dmsr_pkg::cfg_rate_t step,
    output dmsr_pkg::rate_t     nxt
);
    import dmsr_pkg::*;

    sum_t cur_w;
    sum_t tgt_w;
    sum_t step_w;
    sum_t up_w;
    sum_t down_w;

    assign cur_w  = sum_t'(cur);
    assign tgt_w  = sum_t'(tgt);
    assign step_w = sum_t'(step);
    assign up_w   = cur_w + step_w;
    assign down_w = (cur_w > step_w) ? (cur_w - step_w) : '0;

    always_comb begin
        nxt = cur;
        if (cur_w < tgt_w) begin
            nxt = (up_w > tgt_w) ? tgt : rate_t'(up_w);
        end else if (cur_w > tgt_w) begin
            nxt = (down_w < tgt_w) ? tgt : rate_t'(down_w);
        end
    end

endmodule

// ===== bench/dual_motor_speed_ramp_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_motor_speed_ramp_tb
// self-checking bench for the two-motor pulse rate ramp generator
// ----------------------------------------------------------------------------
// Items go in through a valid/ready channel driven at the falling edge. A
// local model of the drive state (enable, targets, current rates, direction
// latches) works out the result of every accepted item. A checker pops the
// oldest expected result for each result item taken at the rising edge.
// The run covers directed corner cases, register extremes, random command
// and tick streams under several register settings, a long result stall, a
// drain pause and a final stretch with no idling on either side.
// ----------------------------------------------------------------------------
module dual_motor_speed_ramp_tb;
    import dmsr_pkg::*;

    // action code that the block does not define
    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    // highest command code, outside the motion table
    localparam logic [3:0] CMD_UNKNOWN = 4'd15;

    typedef struct packed {
        rate_t rate_left;
        rate_t rate_right;
        logic  dir_left;
        logic  dir_right;
        logic  enable_n;
    } drive_out_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     s_valid;
    logic                     s_ready;
    logic [1:0]               s_action;
    logic [3:0]               s_command;
    logic                     s_enable_value;
    logic                     m_valid;
    logic                     m_ready;
    out_rate_t                m_rate_left;
    out_rate_t                m_rate_right;
    logic                     m_dir_pin_left;
    logic                     m_dir_pin_right;
    logic                     m_enable_pin_level;

    // drive model state and register copies
    logic      drv_on;
    rate_t     cur_l, cur_r, tgt_l, tgt_r;
    logic      fwd_l, fwd_r, pin_l, pin_r;
    cfg_rate_t cfg_fast, cfg_slow, cfg_step;
    logic      cfg_inv_l, cfg_inv_r;

    drive_out_t expected_drive[$];
    int         fail_count = 0;
    bit         gaps_enabled = 1'b1;
    int         rx_hold_cycles = 0;

    dual_motor_speed_ramp uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_command          (s_command),
        .s_enable_value     (s_enable_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_rate_left        (m_rate_left),
        .m_rate_right       (m_rate_right),
        .m_dir_pin_left     (m_dir_pin_left),
        .m_dir_pin_right    (m_dir_pin_right),
        .m_enable_pin_level (m_enable_pin_level)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // clamp a register rate into the rate range
    function automatic rate_t to_rate_range(cfg_rate_t v);
        sum_t wide;
        wide = sum_t'(v);
        return (wide > sum_t'(RATE_MAX)) ? RATE_MAX : rate_t'(wide);
    endfunction

    // one ramp step toward the target, never past it and never below zero
    function automatic rate_t ramp_toward(rate_t cur, rate_t tgt, cfg_rate_t step);
        sum_t  up;
        rate_t nxt;
        nxt = cur;
        if (cur < tgt) begin
            up = sum_t'(cur) + sum_t'(step);
            nxt = (up > sum_t'(tgt)) ? tgt : rate_t'(up);
        end else if (cur > tgt) begin
            nxt = (sum_t'(cur) > sum_t'(step)) ? rate_t'(sum_t'(cur) - sum_t'(step)) : '0;
            if (nxt < tgt) begin
                nxt = tgt;
            end
        end
        return nxt;
    endfunction

    // advance the drive model by one accepted item and queue its result
    task automatic predict_drive(logic [1:0] act, logic [3:0] cmd, logic en);
        rate_t      f;
        rate_t      s;
        drive_out_t res;
        f = to_rate_range(cfg_fast);
        s = to_rate_range(cfg_slow);
        case (act)
            ACT_TICK: begin
                if (!drv_on) begin
                    {cur_l, cur_r, tgt_l, tgt_r} = '0;
                end else begin
                    pin_l = fwd_l ^ cfg_inv_l;
                    pin_r = fwd_r ^ cfg_inv_r;
                    cur_l = ramp_toward(cur_l, tgt_l, cfg_step);
                    cur_r = ramp_toward(cur_r, tgt_r, cfg_step);
                end
            end
            ACT_COMMAND: begin
                if (!drv_on) begin
                    {tgt_l, tgt_r} = '0;
                end else begin
                    case (cmd)
                        CMD_FWD:        {fwd_l, fwd_r, tgt_l, tgt_r} = {2'b11, f, f};
                        CMD_BACK:       {fwd_l, fwd_r, tgt_l, tgt_r} = {2'b00, f, f};
                        CMD_SPIN_LEFT:  {fwd_l, fwd_r, tgt_l, tgt_r} = {2'b01, f, f};
                        CMD_SPIN_RIGHT: {fwd_l, fwd_r, tgt_l, tgt_r} = {2'b10, f, f};
                        CMD_FWD_LEFT:   {fwd_l, fwd_r, tgt_l, tgt_r} = {2'b11, s, f};
                        CMD_FWD_RIGHT:  {fwd_l, fwd_r, tgt_l, tgt_r} = {2'b11, f, s};
                        CMD_BACK_LEFT:  {fwd_l, fwd_r, tgt_l, tgt_r} = {2'b00, s, f};
                        CMD_BACK_RIGHT: {fwd_l, fwd_r, tgt_l, tgt_r} = {2'b00, f, s};
                        // stop and unknown codes keep the directions
                        default:        {tgt_l, tgt_r} = '0;
                    endcase
                end
            end
            ACT_ENABLE: begin
                if (!en) begin
                    {cur_l, cur_r, tgt_l, tgt_r} = '0;
                end
                drv_on = en;
            end
            default: ;
        endcase
        res.rate_left  = cur_l;
        res.rate_right = cur_r;
        res.dir_left   = pin_l;
        res.dir_right  = pin_r;
        res.enable_n   = ~drv_on;
        expected_drive.push_back(res);
    endtask

    // register write: setup cycle, then access cycle
    task automatic apb_write(reg_idx_t idx, logic [31:0] data);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_FAST_RATE:        cfg_fast  = data[15:0];
            REG_SLOW_RATE:        cfg_slow  = data[15:0];
            REG_RAMP_INCREMENT:   cfg_step  = data[15:0];
            REG_INVERT_LEFT_DIR:  cfg_inv_l = data[0];
            REG_INVERT_RIGHT_DIR: cfg_inv_r = data[0];
            default: ;
        endcase
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // offer one item and hold it until the block takes it
    task automatic send_item(logic [1:0] act, logic [3:0] cmd, logic en);
        int gap;
        @(negedge aclk);
        if (gaps_enabled && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_action       = act;
        s_command      = cmd;
        s_enable_value = en;
        s_valid        = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_drive(act, cmd, en);
    endtask

    // stop offering and wait until every expected result has come out
    task automatic wait_drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_drive.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic apply_config(logic [31:0] fast, logic [31:0] slow, logic [31:0] step,
                                logic [31:0] inv_l, logic [31:0] inv_r);
        wait_drain();
        apb_write(REG_FAST_RATE, fast);
        apb_write(REG_SLOW_RATE, slow);
        apb_write(REG_RAMP_INCREMENT, step);
        apb_write(REG_INVERT_LEFT_DIR, inv_l);
        apb_write(REG_INVERT_RIGHT_DIR, inv_r);
    endtask

    // mostly ticks with enabled commands in between, some noise
    task automatic send_random_item();
        int         pick;
        logic [1:0] act;
        logic [3:0] cmd;
        logic       en;
        pick = $urandom_range(0, 99);
        cmd  = 4'($urandom_range(0, 15));
        en   = 1'($urandom_range(0, 1));
        if (pick < 12) begin
            act = ACT_COMMAND;
            cmd = (pick < 10) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
        end else if (pick < 16) begin
            act = ACT_ENABLE;
            en  = 1'b1;
        end else if (pick < 17) begin
            act = ACT_ENABLE;
            en  = 1'b0;
        end else if (pick < 19) begin
            act = ACT_UNUSED;
        end else begin
            act = ACT_TICK;
        end
        send_item(act, cmd, en);
    endtask

    // reset settings: disabled behavior, every moving command, unknown codes
    task automatic test_directed();
        send_item(ACT_TICK, CMD_HALT, 1'b0);
        send_item(ACT_COMMAND, CMD_FWD, 1'b0);
        send_item(ACT_UNUSED, CMD_UNKNOWN, 1'b1);
        send_item(ACT_ENABLE, CMD_HALT, 1'b0);
        send_item(ACT_ENABLE, CMD_HALT, 1'b1);
        send_item(ACT_ENABLE, CMD_HALT, 1'b1);
        send_item(ACT_COMMAND, CMD_FWD, 1'b0);
        send_item(ACT_TICK, CMD_HALT, 1'b0);
        for (int c = CMD_BACK; c <= CMD_BACK_RIGHT; c++) begin
            send_item(ACT_COMMAND, 4'(c), 1'b0);
            send_item(ACT_TICK, CMD_UNKNOWN, 1'b1);
        end
        send_item(ACT_COMMAND, CMD_UNKNOWN, 1'b1);
        send_item(ACT_TICK, CMD_HALT, 1'b0);
        send_item(ACT_ENABLE, CMD_UNKNOWN, 1'b0);
        send_item(ACT_TICK, CMD_FWD, 1'b1);
        wait_drain();
    endtask

    // full-scale rates, huge and zero increments, inversion flips
    task automatic test_config_extremes();
        apply_config(32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0001_FFFF, 32'hFFFF_FFFE, 32'h0000_0001);
        send_item(ACT_ENABLE, CMD_HALT, 1'b1);
        send_item(ACT_COMMAND, CMD_FWD_LEFT, 1'b0);
        send_item(ACT_TICK, CMD_HALT, 1'b0);
        send_item(ACT_COMMAND, CMD_BACK_RIGHT, 1'b0);
        send_item(ACT_TICK, CMD_HALT, 1'b0);
        send_item(ACT_TICK, CMD_HALT, 1'b0);
        send_item(ACT_COMMAND, CMD_SPIN_LEFT, 1'b0);
        send_item(ACT_TICK, CMD_HALT, 1'b0);
        send_item(ACT_COMMAND, CMD_HALT, 1'b0);
        send_item(ACT_TICK, CMD_HALT, 1'b0);
        apply_config(32'd1000, 32'd999, 32'd300, 32'd1, 32'd0);
        send_item(ACT_COMMAND, CMD_FWD, 1'b0);
        send_item(ACT_TICK, CMD_HALT, 1'b0);
        send_item(ACT_TICK, CMD_HALT, 1'b0);
        // zero increment: rates hold, pins still follow the new inversion
        apply_config(32'd1000, 32'd999, 32'd0, 32'd0, 32'd1);
        send_item(ACT_TICK, CMD_HALT, 1'b0);
        send_item(ACT_COMMAND, CMD_HALT, 1'b0);
        send_item(ACT_TICK, CMD_HALT, 1'b0);
        apply_config(32'd1000, 32'd999, 32'd1, 32'd1, 32'd1);
        send_item(ACT_COMMAND, CMD_BACK, 1'b0);
        send_item(ACT_TICK, CMD_HALT, 1'b0);
        send_item(ACT_TICK, CMD_HALT, 1'b0);
        wait_drain();
    endtask

    task automatic test_random_phases();
        logic [31:0] fast, slow, step, inv_l, inv_r;
        for (int p = 0; p < 6; p++) begin
            fast  = $urandom();
            slow  = $urandom();
            step  = $urandom();
            inv_l = $urandom();
            inv_r = $urandom();
            fast[15:0] = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(0, 2000));
            slow[15:0] = ($urandom_range(0, 5) == 0) ? 16'h0000 : 16'($urandom_range(0, 2000));
            step[15:0] = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom_range(1, 250));
            apply_config(fast, slow, step, inv_l, inv_r);
            // stretches without idling on every third phase
            gaps_enabled = (p % 3 != 2);
            send_item(ACT_ENABLE, 4'($urandom_range(0, 15)), 1'b1);
            repeat (140) send_random_item();
        end
        wait_drain();
        gaps_enabled = 1'b1;
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_result_backpressure();
        gaps_enabled   = 1'b0;
        rx_hold_cycles = 60;
        send_item(ACT_ENABLE, CMD_HALT, 1'b1);
        send_item(ACT_COMMAND, CMD_FWD_RIGHT, 1'b0);
        repeat (23) send_random_item();
        wait_drain();
        gaps_enabled = 1'b1;
    endtask

    // sender stops until every result is back, then carries on
    task automatic test_sender_pause();
        repeat (20) send_random_item();
        wait_drain();
        repeat (20) send_random_item();
        wait_drain();
    endtask

    task automatic test_back_to_back();
        gaps_enabled = 1'b0;
        send_item(ACT_ENABLE, CMD_HALT, 1'b1);
        repeat (120) send_random_item();
        wait_drain();
    endtask

    // result side: long hold when asked, otherwise random stall bursts
    initial begin : result_ready_driver
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_ready = 1'b0;
                rx_hold_cycles--;
            end else if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else if (gaps_enabled && $urandom_range(0, 4) == 0) begin
                m_ready = 1'b0;
                stall_left = $urandom_range(1, 13) - 1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_checker
        drive_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_drive.size() == 0) begin
                fail_count++;
                $display("%0t: result item with no pending expectation", $time);
            end else begin
                want = expected_drive.pop_front();
                check_field("rate_left", 32'(want.rate_left), 32'(m_rate_left));
                check_field("rate_right", 32'(want.rate_right), 32'(m_rate_right));
                check_field("dir_pin_left", 32'(want.dir_left), 32'(m_dir_pin_left));
                check_field("dir_pin_right", 32'(want.dir_right), 32'(m_dir_pin_right));
                check_field("enable_pin_level", 32'(want.enable_n), 32'(m_enable_pin_level));
            end
        end
    end

    initial begin : watchdog
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : test_sequence
        aresetn        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_valid        = 1'b0;
        s_action       = ACT_TICK;
        s_command      = CMD_HALT;
        s_enable_value = 1'b0;
        // model state after reset
        drv_on    = 1'b0;
        {cur_l, cur_r, tgt_l, tgt_r} = '0;
        fwd_l     = 1'b1;
        fwd_r     = 1'b1;
        pin_l     = 1'b0;
        pin_r     = 1'b1;
        cfg_fast  = FAST_RATE_RESET;
        cfg_slow  = SLOW_RATE_RESET;
        cfg_step  = RAMP_INC_RESET;
        cfg_inv_l = 1'b1;
        cfg_inv_r = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_config_extremes();
        test_random_phases();
        test_result_backpressure();
        test_sender_pause();
        test_back_to_back();

        wait_drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/dmsr_pkg.sv
sv/dmsr_ramp_step.sv
sv/dual_motor_speed_ramp.sv
bench/dual_motor_speed_ramp_tb.sv
